// ===== hdl/u8dw_pkg.sv =====
// package for the utf-8 decoder with display width fitting
// holds the queue item types, constants and the display width function
// no dependencies
`timescale 1ns / 1ps

package u8dw_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodeW      = 21;
  localparam int unsigned CountW     = 3;
  localparam int unsigned CharWidthW = 2;
  localparam int unsigned LineW      = 8;
  localparam int unsigned MaxChars   = 4;
  localparam int unsigned CharIdxW   = $clog2(MaxChars);
  localparam int unsigned PendDepth  = 3;
  localparam int unsigned PendCountW = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [LineW-1:0] MaxWidthReset = 8'd16;

  // display width codes
  localparam logic [CharWidthW-1:0] WidthCtrl   = 2'd0;
  localparam logic [CharWidthW-1:0] WidthNarrow = 2'd1;
  localparam logic [CharWidthW-1:0] WidthWide   = 2'd2;

  // lead byte lengths
  localparam logic [CountW-1:0] LenNone = 3'd0;
  localparam logic [CountW-1:0] LenOne  = 3'd1;
  localparam logic [CountW-1:0] LenTwo  = 3'd2;
  localparam logic [CountW-1:0] LenThree = 3'd3;
  localparam logic [CountW-1:0] LenFour = 3'd4;

  localparam logic [CodeW-1:0] SurrLo   = 21'h00D800;
  localparam logic [CodeW-1:0] SurrHi   = 21'h00DFFF;
  localparam logic [CodeW-1:0] CodeMax  = 21'h10FFFF;
  localparam logic [CodeW-1:0] MinTwo   = 21'h000080;
  localparam logic [CodeW-1:0] MinThree = 21'h000800;
  localparam logic [CodeW-1:0] MinFour  = 21'h010000;

  typedef struct packed {
    logic [CodeW-1:0]  cp;
    logic [CountW-1:0] cnt;   // zero marks the end marker
  } char_t;

  // one queue item: every character caused by one accepted byte
  typedef struct packed {
    char_t [MaxChars-1:0] chars;
    logic [CharIdxW-1:0]  last_idx;
    logic                 closes;   // the text ends with this group
  } group_t;

  function automatic logic [CharWidthW-1:0] cp_width(input logic [CodeW-1:0] cp);
    logic wide;
    wide = (cp >= 21'h01100 && cp <= 21'h0115F) || (cp >= 21'h02E80 && cp <= 21'h0A4CF) ||
           (cp >= 21'h0AC00 && cp <= 21'h0D7A3) || (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
           (cp >= 21'h0FE10 && cp <= 21'h0FE19) || (cp >= 21'h0FE30 && cp <= 21'h0FE6F) ||
           (cp >= 21'h0FF00 && cp <= 21'h0FF60) || (cp >= 21'h0FFE0 && cp <= 21'h0FFE6) ||
           (cp >= 21'h1F300 && cp <= 21'h1FAFF);
    if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) begin
      return WidthCtrl;
    end else if (wide) begin
      return WidthWide;
    end
    return WidthNarrow;
  endfunction

endpackage

// ===== hdl/u8dw_front.sv =====
// front end: utf-8 sequence decoder, one byte per accepted item
// builds a group of up to four characters for the queue; uses u8dw_pkg
`timescale 1ns / 1ps

module u8dw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [u8dw_pkg::ByteW-1:0]    text_byte_i,
  input  logic                          end_of_text_i,
  input  logic                          accept_i,
  output u8dw_pkg::group_t              group_o,
  output logic                          group_valid_o
);

  logic [u8dw_pkg::ByteW-1:0]      pend_q [u8dw_pkg::PendDepth];
  logic [u8dw_pkg::ByteW-1:0]      pend_d [u8dw_pkg::PendDepth];
  logic [u8dw_pkg::PendCountW-1:0] pcount_q, pcount_d;
  logic [u8dw_pkg::CountW-1:0]     explen_q, explen_d;
  logic [u8dw_pkg::CodeW-1:0]      partial_q, partial_d;

  logic [u8dw_pkg::CountW-1:0]     n;
  logic [u8dw_pkg::CountW-1:0]     lead_len;
  logic [u8dw_pkg::CodeW-1:0]      lead_bits;
  logic [u8dw_pkg::CodeW-1:0]      newp;
  logic [u8dw_pkg::CodeW-1:0]      lo;
  logic                            zero_b, cont, closing, done, bad;
  logic                            flush_go, fresh_go, raw_go, good_go, store_go;
  u8dw_pkg::group_t                grp;

  // lead byte class
  always_comb begin
    lead_len  = u8dw_pkg::LenNone;
    lead_bits = '0;
    priority if (text_byte_i[7:5] == 3'b110) begin
      lead_len  = u8dw_pkg::LenTwo;
      lead_bits = {16'b0, text_byte_i[4:0]};
    end else if (text_byte_i[7:4] == 4'b1110) begin
      lead_len  = u8dw_pkg::LenThree;
      lead_bits = {17'b0, text_byte_i[3:0]};
    end else if (text_byte_i[7:3] == 5'b11110) begin
      lead_len  = u8dw_pkg::LenFour;
      lead_bits = {18'b0, text_byte_i[2:0]};
    end else begin
      lead_len  = u8dw_pkg::LenNone;
    end
  end

  always_comb begin
    zero_b   = (text_byte_i == '0);
    cont     = (text_byte_i[7:6] == 2'b10);
    closing  = zero_b || end_of_text_i;
    newp     = {partial_q[u8dw_pkg::CodeW-7:0], text_byte_i[5:0]};
    done     = ({1'b0, pcount_q} + 3'd1) >= explen_q;
    unique case (explen_q)
      u8dw_pkg::LenTwo:   lo = u8dw_pkg::MinTwo;
      u8dw_pkg::LenThree: lo = u8dw_pkg::MinThree;
      default:            lo = u8dw_pkg::MinFour;
    endcase
    bad = (newp < lo) || (newp >= u8dw_pkg::SurrLo && newp <= u8dw_pkg::SurrHi) ||
          (newp > u8dw_pkg::CodeMax);

    flush_go = 1'b0;
    fresh_go = 1'b0;
    raw_go   = 1'b0;
    good_go  = 1'b0;
    store_go = 1'b0;
    if (zero_b) begin
      flush_go = 1'b1;
    end else if (explen_q != u8dw_pkg::LenNone) begin
      if (!cont) begin
        flush_go = 1'b1;
        fresh_go = 1'b1;
      end else if (done) begin
        flush_go = bad;
        raw_go   = bad;
        good_go  = !bad;
      end else begin
        store_go = 1'b1;
      end
    end else begin
      fresh_go = 1'b1;
    end
  end

  // assemble the character list in order
  always_comb begin
    pend_d    = pend_q;
    pcount_d  = pcount_q;
    explen_d  = explen_q;
    partial_d = partial_q;
    grp       = '0;
    n         = '0;

    if (flush_go) begin
      for (int i = 0; i < u8dw_pkg::PendDepth; i++) begin
        if (u8dw_pkg::PendCountW'(i) < pcount_q) begin
          grp.chars[n[u8dw_pkg::CharIdxW-1:0]] = '{cp: {13'b0, pend_q[i]},
                                                   cnt: u8dw_pkg::LenOne};
          n = n + 3'd1;
        end
      end
      pcount_d  = '0;
      explen_d  = u8dw_pkg::LenNone;
      partial_d = '0;
    end
    // end marker
    if (zero_b) begin
      grp.chars[n[u8dw_pkg::CharIdxW-1:0]] = '{cp: '0, cnt: u8dw_pkg::LenNone};
      n = n + 3'd1;
    end
    if (raw_go) begin
      grp.chars[n[u8dw_pkg::CharIdxW-1:0]] = '{cp: {13'b0, text_byte_i},
                                               cnt: u8dw_pkg::LenOne};
      n = n + 3'd1;
    end
    if (good_go) begin
      grp.chars[n[u8dw_pkg::CharIdxW-1:0]] = '{cp: newp, cnt: explen_q};
      n = n + 3'd1;
      pcount_d  = '0;
      explen_d  = u8dw_pkg::LenNone;
      partial_d = '0;
    end
    if (store_go) begin
      pend_d[pcount_q] = text_byte_i;
      pcount_d         = pcount_q + 2'd1;
      partial_d        = newp;
    end
    if (fresh_go) begin
      if (lead_len == u8dw_pkg::LenNone) begin
        grp.chars[n[u8dw_pkg::CharIdxW-1:0]] = '{cp: {13'b0, text_byte_i},
                                                 cnt: u8dw_pkg::LenOne};
        n = n + 3'd1;
      end else begin
        pend_d[0] = text_byte_i;
        pcount_d  = 2'd1;
        explen_d  = lead_len;
        partial_d = lead_bits;
      end
    end
    // end flag on a nonzero byte flushes what is still open
    if (closing && !zero_b) begin
      for (int i = 0; i < u8dw_pkg::PendDepth; i++) begin
        if (u8dw_pkg::PendCountW'(i) < pcount_d) begin
          grp.chars[n[u8dw_pkg::CharIdxW-1:0]] = '{cp: {13'b0, pend_d[i]},
                                                   cnt: u8dw_pkg::LenOne};
          n = n + 3'd1;
        end
      end
    end
    if (closing) begin
      pcount_d  = '0;
      explen_d  = u8dw_pkg::LenNone;
      partial_d = '0;
    end
    grp.last_idx  = u8dw_pkg::CharIdxW'(n - 3'd1);
    grp.closes    = closing;
  end

  assign group_o       = grp;
  assign group_valid_o = accept_i && (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q  <= '0;
      explen_q  <= u8dw_pkg::LenNone;
      partial_q <= '0;
    end else if (accept_i) begin
      pcount_q  <= pcount_d;
      explen_q  <= explen_d;
      partial_q <= partial_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

// ===== hdl/u8dw_queue.sv =====
// small queue of character groups between decoder and width stage
// uses u8dw_pkg
`timescale 1ns / 1ps

module u8dw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u8dw_pkg::group_t data_i,
  input  logic             pop_i,
  output u8dw_pkg::group_t data_o,
  output logic             valid_o,
  output logic             full_o
);

  u8dw_pkg::group_t                 mem_q [u8dw_pkg::QueueDepth];
  logic [u8dw_pkg::QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [u8dw_pkg::QueueCntW-1:0]   count_q, count_d;

  localparam logic [u8dw_pkg::QueuePtrW-1:0] LastSlot =
    u8dw_pkg::QueuePtrW'(u8dw_pkg::QueueDepth - 1);

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == u8dw_pkg::QueueCntW'(u8dw_pkg::QueueDepth));
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/u8dw_back.sv =====
// back end: display width, width sum and fit tracking, one character per cycle
// while the output is not stalled; walks the queue head group and drives the registered result; uses u8dw_pkg
`timescale 1ns / 1ps

module u8dw_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  u8dw_pkg::group_t                   head_i,
  input  logic                               head_valid_i,
  output logic                               pop_o,
  input  logic [u8dw_pkg::LineW-1:0]         max_width_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [u8dw_pkg::CodeW-1:0]         code_point_o,
  output logic [u8dw_pkg::CountW-1:0]        byte_count_o,
  output logic [u8dw_pkg::CharWidthW-1:0]    char_width_o,
  output logic [u8dw_pkg::LineW-1:0]         line_width_o,
  output logic                               fits_o,
  output logic                               last_o
);

  logic [u8dw_pkg::CharIdxW-1:0]   idx_q, idx_d;
  logic [u8dw_pkg::LineW-1:0]      sum_q, sum_d;
  logic                            stopped_q, stopped_d;
  logic                            out_valid_q, out_valid_d;
  logic [u8dw_pkg::CodeW-1:0]      cp_q;
  logic [u8dw_pkg::CountW-1:0]     cnt_q;
  logic [u8dw_pkg::CharWidthW-1:0] w_q;
  logic [u8dw_pkg::LineW-1:0]      line_q, line_d;
  logic                            fits_q, last_q, last_d;

  u8dw_pkg::char_t                 cur;
  logic [u8dw_pkg::CharWidthW-1:0] w;
  logic [u8dw_pkg::LineW:0]        wide_sum;
  logic                            fit, step, end_item;

  always_comb begin
    step     = head_valid_i && (!out_valid_q || out_ready_i);
    cur      = head_i.chars[idx_q];
    w        = u8dw_pkg::cp_width(cur.cp);
    wide_sum = {1'b0, sum_q} + {7'b0, w};
    // the end marker only tells whether the text stayed within the limit
    fit      = !stopped_q && ((cur.cnt == u8dw_pkg::LenNone) ||
                              (wide_sum <= {1'b0, max_width_i}));
    end_item = (idx_q == head_i.last_idx);
    last_d   = head_i.closes && end_item;
    line_d   = fit ? wide_sum[u8dw_pkg::LineW-1:0] : sum_q;

    idx_d       = idx_q;
    sum_d       = sum_q;
    stopped_d   = stopped_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (step) begin
      out_valid_d = 1'b1;
      idx_d       = end_item ? '0 : idx_q + 1'b1;
      if (last_d) begin
        // text done: start the next one fresh
        sum_d     = '0;
        stopped_d = 1'b0;
      end else begin
        sum_d     = line_d;
        stopped_d = stopped_q || !fit;
      end
    end
  end

  assign pop_o = step && end_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      sum_q       <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      cp_q   <= cur.cp;
      cnt_q  <= cur.cnt;
      w_q    <= w;
      line_q <= line_d;
      fits_q <= fit;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign byte_count_o = cnt_q;
  assign char_width_o = w_q;
  assign line_width_o = line_q;
  assign fits_o       = fits_q;
  assign last_o       = last_q;

endmodule

// ===== hdl/utf8_decode_width_fit_top.sv =====
// the byte that completes a result item pushes it into the queue; the width stage then registers it as output
// throughput: one byte per cycle while each byte yields at most one character and the output is not stalled;
//   a byte that yields more characters (error replay, end marker) takes the width stage once for each
// a four-group queue lets the decoder keep accepting during such bursts
// reset (async, active low): decoder and width sum cleared, max_width back to 16
// depends on u8dw_pkg, u8dw_front, u8dw_queue, u8dw_back
`timescale 1ns / 1ps

module utf8_decode_width_fit_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: max_width, written on cfg_we_i
  input  logic                               cfg_we_i,
  input  logic [u8dw_pkg::LineW-1:0]         cfg_data_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [u8dw_pkg::ByteW-1:0]         text_byte_i,
  input  logic                               end_of_text_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [u8dw_pkg::CodeW-1:0]         code_point_o,
  output logic [u8dw_pkg::CountW-1:0]        byte_count_o,
  output logic [u8dw_pkg::CharWidthW-1:0]    char_width_o,
  output logic [u8dw_pkg::LineW-1:0]         line_width_o,
  output logic                               fits_o,
  output logic                               last_o
);

  logic [u8dw_pkg::LineW-1:0] max_width_q;
  logic                       accept;
  logic                       q_full, q_valid, q_pop, grp_valid;
  u8dw_pkg::group_t           grp, head;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q <= u8dw_pkg::MaxWidthReset;
    end else if (cfg_we_i) begin
      max_width_q <= cfg_data_i;
    end
  end

  // every accepted byte needs at most one queue slot
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // decoder: turns each byte into a group of zero to four characters
  u8dw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .accept_i      (accept),
    .group_o       (grp),
    .group_valid_o (grp_valid)
  );

  // groups with no character (mid-sequence bytes) are not queued
  u8dw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_valid),
    .data_i  (grp),
    .pop_i   (q_pop),
    .data_o  (head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  // width stage: one character per cycle into the output register while the output is not stalled
  u8dw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_valid),
    .pop_o        (q_pop),
    .max_width_i  (max_width_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .byte_count_o (byte_count_o),
    .char_width_o (char_width_o),
    .line_width_o (line_width_o),
    .fits_o       (fits_o),
    .last_o       (last_o)
  );

endmodule
